// ===== sv/shc_pkg.sv =====
// shared types, constants and sharpen arithmetic for the sharpen filter
package shc_pkg;

  localparam int unsigned MaxWidth   = 2048;
  localparam int unsigned ColW       = $clog2(MaxWidth);
  localparam int unsigned WidthRegW  = 12;
  localparam int unsigned HeightRegW = 16;
  localparam int unsigned RowW       = 16;
  localparam int unsigned ChanW      = 8;
  localparam int unsigned CfgAddrW   = 1;
  localparam int unsigned CfgDataW   = 16;
  localparam int unsigned InTdataW   = 24;
  localparam int unsigned OutTdataW  = 56;
  localparam int unsigned SumW       = 12;

  localparam logic [WidthRegW-1:0]  WidthReset  = WidthRegW'(2048);
  localparam logic [HeightRegW-1:0] HeightReset = HeightRegW'(1);
  localparam logic [ChanW-1:0]      ChanMax     = '1;

  typedef enum logic [CfgAddrW-1:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

  // red in the lowest bits, as on the stream
  typedef struct packed {
    logic [ChanW-1:0] blue;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] red;
  } pixel_t;

  typedef struct packed {
    logic            en;
    logic [ColW-1:0] addr;
  } lb_rd_t;

  typedef struct packed {
    logic            en;
    logic [ColW-1:0] addr;
    pixel_t          pix;
    pixel_t          above;
  } lb_wr_t;

  typedef struct packed {
    logic            frame_end;
    pixel_t          pix;
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
  } result_t;

  // 5*c - t - b - l - r, saturated to the channel range
  function automatic logic [ChanW-1:0] sharpen_chan(
    input logic [ChanW-1:0] c,
    input logic [ChanW-1:0] t,
    input logic [ChanW-1:0] b,
    input logic [ChanW-1:0] l,
    input logic [ChanW-1:0] r
  );
    logic [SumW-1:0] pos;
    logic [SumW-1:0] neg;
    logic [SumW-1:0] diff;
    logic [ChanW-1:0] res;
    pos  = {c, 2'b00} + SumW'(c);
    neg  = SumW'(t) + SumW'(b) + SumW'(l) + SumW'(r);
    diff = pos - neg;
    if (pos < neg) begin
      res = '0;
    end else if (diff > SumW'(ChanMax)) begin
      res = ChanMax;
    end else begin
      res = diff[ChanW-1:0];
    end
    return res;
  endfunction

  function automatic pixel_t sharpen(
    input pixel_t c,
    input pixel_t t,
    input pixel_t b,
    input pixel_t l,
    input pixel_t r
  );
    pixel_t res;
    res.red   = sharpen_chan(c.red, t.red, b.red, l.red, r.red);
    res.green = sharpen_chan(c.green, t.green, b.green, l.green, r.green);
    res.blue  = sharpen_chan(c.blue, t.blue, b.blue, l.blue, r.blue);
    return res;
  endfunction

endpackage

// ===== sv/shc_line_buf.sv =====
// two line buffer memories with write-to-read forwarding
module shc_line_buf (
  input  logic            clk_i,
  input  shc_pkg::lb_rd_t rd_i,
  input  shc_pkg::lb_wr_t wr_i,
  output shc_pkg::pixel_t above_here_o,
  output shc_pkg::pixel_t above_right_o,
  output shc_pkg::pixel_t two_above_o
);
  import shc_pkg::*;

  pixel_t above_mem [MaxWidth];
  pixel_t two_mem   [MaxWidth];

  logic [ColW-1:0] rd_next_addr;
  pixel_t          above_q;
  pixel_t          right_q;
  pixel_t          two_q;
  logic            byp_here_q;
  logic            byp_right_q;
  pixel_t          byp_pix_q;
  pixel_t          byp_above_q;

  assign rd_next_addr = rd_i.addr + 1'b1;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      above_mem[wr_i.addr] <= wr_i.pix;
      two_mem[wr_i.addr]   <= wr_i.above;
    end
    if (rd_i.en) begin
      above_q <= above_mem[rd_i.addr];
      right_q <= above_mem[rd_next_addr];
      two_q   <= two_mem[rd_i.addr];
    end
  end

  // a write in the read cycle is not yet in the array: catch it here
  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      byp_here_q  <= wr_i.en && (wr_i.addr == rd_i.addr);
      byp_right_q <= wr_i.en && (wr_i.addr == rd_next_addr);
      byp_pix_q   <= wr_i.pix;
      byp_above_q <= wr_i.above;
    end
  end

  assign above_here_o  = byp_here_q  ? byp_pix_q   : above_q;
  assign above_right_o = byp_right_q ? byp_pix_q   : right_q;
  assign two_above_o   = byp_here_q  ? byp_above_q : two_q;

endmodule

// ===== sv/sharpen_3x3_convolution_top.sv =====
// top level of the 3x3 sharpen filter over an rgb pixel stream
//
// pixels enter on the s_axis channel in raster order, one word per pixel.
// image width and height are set through the cfg write channel while the
// block is idle; cfg_ready_o is always high. a width of 0 counts as 1, a
// width above 2048 counts as 2048, a height of 0 counts as 1.
// results leave on m_axis: one per pixel from the second row on (the pixel
// one row up), and on the last row also the pixel to the left, plus the
// row's final pixel itself. tlast marks the last result of an input word,
// tuser marks the result for the image's final pixel.
// a word passes through the compute stage and then the output group, both registered, before its results are offered.
// throughput: one pixel per clock while m_axis keeps up, set by the single
// read/modify/write pass through the line buffer memories per pixel; on the
// last row of a taller image each pixel after the first gives two results
// (three for the row's last pixel), so the output port paces the input.
// reset clears the counters and the pipeline; line buffers are not cleared.
// when m_axis stalls, the held results stay put and input is taken until
// the single pipeline stage behind the output group is full.
module sharpen_3x3_convolution_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // stream in
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [shc_pkg::InTdataW-1:0]         s_axis_tdata,   // in_red, in_green, in_blue
  // stream out
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [shc_pkg::OutTdataW-1:0]        m_axis_tdata,   // out_col, out_row, out_red,
                                                               // out_green, out_blue, zero pad
  output logic                                 m_axis_tlast,   // run_last
  output logic                                 m_axis_tuser,   // frame_end
  // configuration writes
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [shc_pkg::CfgAddrW-1:0]         cfg_addr_i,
  input  logic [shc_pkg::CfgDataW-1:0]         cfg_data_i
);
  import shc_pkg::*;

  // configuration registers
  logic [WidthRegW-1:0]  width_q;
  logic [HeightRegW-1:0] height_q;
  logic [WidthRegW-1:0]  w_eff;
  logic [HeightRegW-1:0] h_eff;

  // raster position of the next word
  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic            row_end;
  logic            last_row;
  logic            in_acc;

  // compute stage, one word deep
  logic            s1_valid_q, s1_valid_d;
  logic [ColW-1:0] s1_x_q;
  logic [RowW-1:0] s1_y_q;
  logic            s1_row_end_q;
  logic            s1_last_row_q;
  pixel_t          s1_pix_q;

  // current row at x-1, x-2, row above at x-1
  pixel_t rec0_q, rec1_q, rec2_q;

  // line buffer interface
  lb_rd_t lb_rd;
  lb_wr_t lb_wr;
  pixel_t above_here;
  pixel_t above_right_raw;
  pixel_t two_above;
  pixel_t above_right;

  // neighbours and results of the word in the compute stage
  pixel_t  top0, left0, top1, left1, top2, left2;
  result_t res0, res1, res2;
  logic [2:0] new_mask;

  // output group: up to three results of one word
  result_t    g_res_q [3];
  logic [2:0] g_mask_q, g_mask_d;
  logic [2:0] sel_oh;
  logic [2:0] rest;
  result_t    sel_res;
  logic       take;
  logic       g_load;

  // ---------------------------------------------------------------
  // configuration
  // ---------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthReset;
      height_q <= HeightReset;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        CFG_IMAGE_WIDTH:  width_q  <= cfg_data_i[WidthRegW-1:0];
        CFG_IMAGE_HEIGHT: height_q <= cfg_data_i[HeightRegW-1:0];
        default: ;
      endcase
    end
  end

  // clamp out-of-range sizes
  always_comb begin
    if (width_q == '0) begin
      w_eff = WidthRegW'(1);
    end else if (width_q > WidthRegW'(MaxWidth)) begin
      w_eff = WidthRegW'(MaxWidth);
    end else begin
      w_eff = width_q;
    end
    h_eff = (height_q == '0) ? HeightRegW'(1) : height_q;
  end

  // ---------------------------------------------------------------
  // raster counters, advanced as each word is taken
  // ---------------------------------------------------------------
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign row_end  = (WidthRegW'(col_q) + WidthRegW'(1)) >= w_eff;
  assign last_row = ({1'b0, row_q} + 17'd1) >= {1'b0, h_eff};

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (in_acc) begin
      if (row_end) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // ---------------------------------------------------------------
  // line buffers: read at accept, write back as the word leaves the
  // compute stage
  // ---------------------------------------------------------------
  assign lb_rd.en   = in_acc;
  assign lb_rd.addr = col_q;

  assign lb_wr.en    = g_load;
  assign lb_wr.addr  = s1_x_q;
  assign lb_wr.pix   = s1_pix_q;
  assign lb_wr.above = above_here;

  shc_line_buf u_line_buf (
    .clk_i         (clk_i),
    .rd_i          (lb_rd),
    .wr_i          (lb_wr),
    .above_here_o  (above_here),
    .above_right_o (above_right_raw),
    .two_above_o   (two_above)
  );

  // ---------------------------------------------------------------
  // compute stage
  // ---------------------------------------------------------------
  assign s_axis_tready = !s1_valid_q || g_load;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (g_load) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_x_q        <= col_q;
      s1_y_q        <= row_q;
      s1_row_end_q  <= row_end;
      s1_last_row_q <= last_row;
      s1_pix_q      <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec0_q <= '0;
      rec1_q <= '0;
      rec2_q <= '0;
    end else if (g_load) begin
      rec0_q <= s1_pix_q;
      rec1_q <= rec0_q;
      rec2_q <= above_here;
    end
  end

  // edge replication at the right border
  assign above_right = s1_row_end_q ? above_here : above_right_raw;

  always_comb begin
    // pixel one row up
    top0  = (s1_y_q == RowW'(1)) ? above_here : two_above;
    left0 = (s1_x_q == '0) ? above_here : rec2_q;
    // pixel to the left on the last row
    top1  = (s1_y_q == '0) ? rec0_q : rec2_q;
    left1 = (s1_x_q == ColW'(1)) ? rec0_q : rec1_q;
    // final pixel of the last row's run
    top2  = (s1_y_q == '0) ? s1_pix_q : above_here;
    left2 = (s1_x_q == '0) ? s1_pix_q : rec0_q;

    res0.col       = s1_x_q;
    res0.row       = s1_y_q - 1'b1;
    res0.pix       = sharpen(above_here, top0, s1_pix_q, left0, above_right);
    res0.frame_end = 1'b0;

    res1.col       = s1_x_q - 1'b1;
    res1.row       = s1_y_q;
    res1.pix       = sharpen(rec0_q, top1, rec0_q, left1, s1_pix_q);
    res1.frame_end = 1'b0;

    res2.col       = s1_x_q;
    res2.row       = s1_y_q;
    res2.pix       = sharpen(s1_pix_q, top2, s1_pix_q, left2, s1_pix_q);
    res2.frame_end = 1'b1;

    new_mask[0] = (s1_y_q != '0);
    new_mask[1] = s1_last_row_q && (s1_x_q != '0);
    new_mask[2] = s1_last_row_q && s1_row_end_q;
  end

  // ---------------------------------------------------------------
  // output group, drained in order one word per handshake
  // ---------------------------------------------------------------
  always_comb begin
    if (g_mask_q[0]) begin
      sel_oh  = 3'b001;
      sel_res = g_res_q[0];
    end else if (g_mask_q[1]) begin
      sel_oh  = 3'b010;
      sel_res = g_res_q[1];
    end else begin
      sel_oh  = 3'b100;
      sel_res = g_res_q[2];
    end
  end

  assign rest   = g_mask_q & ~sel_oh;
  assign take   = m_axis_tvalid && m_axis_tready;
  assign g_load = s1_valid_q && ((g_mask_q == '0) || (take && (rest == '0)));

  always_comb begin
    g_mask_d = g_mask_q;
    if (g_load) begin
      g_mask_d = new_mask;
    end else if (take) begin
      g_mask_d = rest;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_mask_q <= '0;
    end else begin
      g_mask_q <= g_mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (g_load) begin
      g_res_q[0] <= res0;
      g_res_q[1] <= res1;
      g_res_q[2] <= res2;
    end
  end

  assign m_axis_tvalid = (g_mask_q != '0);
  assign m_axis_tlast  = (rest == '0);
  assign m_axis_tuser  = sel_res.frame_end;
  assign m_axis_tdata  = OutTdataW'({sel_res.pix, sel_res.row, sel_res.col});

`ifndef SYNTHESIS
  // final-pixel result is always the last of its word
  a_fend_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("frame end without run end");

  // a word held in the compute stage is not overwritten
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !g_load |=> s1_valid_q && $stable(s1_x_q) && $stable(s1_y_q))
    else $error("compute stage lost a word");

  // column advances by one inside a row
  a_col_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !row_end |=> col_q == $past(col_q) + 1'b1)
    else $error("column count skipped");

  // a taken result leaves the group unless a new word replaces it
  a_mask_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && !g_load |=> g_mask_q == $past(rest))
    else $error("output group drained wrongly");
`endif

endmodule

// ===== tb/sharpen_3x3_convolution_checker.sv =====
// checker for the sharpen filter: predicts every result word and compares it with the output stream
module sharpen_3x3_convolution_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_tvalid_i,
  input  logic                          s_tready_i,
  input  logic [shc_pkg::InTdataW-1:0]  s_tdata_i,
  input  logic                          m_tvalid_i,
  input  logic                          m_tready_i,
  input  logic [shc_pkg::OutTdataW-1:0] m_tdata_i,
  input  logic                          m_tlast_i,
  input  logic                          m_tuser_i,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [shc_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  logic [shc_pkg::CfgDataW-1:0]  cfg_data_i,
  output int                            fail_count_o,
  output int                            pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import shc_pkg::*;

  localparam int MaxReports = 10;

  typedef struct {
    logic [ColW-1:0] col;
    logic [RowW-1:0] row;
    pixel_t          pix;
    logic            run_last;
    logic            frame_end;
  } sharp_res_t;

  logic [WidthRegW-1:0]  width_q;
  logic [HeightRegW-1:0] height_q;
  pixel_t                above_mem [MaxWidth];
  pixel_t                two_above_mem [MaxWidth];
  int unsigned           col_q;
  int unsigned           row_q;
  pixel_t                recent_q [4];
  sharp_res_t            sharpened_q [$];
  int                    mismatch_count = 0;

  // one channel: 5*c minus the four neighbours, clipped to 0..255
  function automatic logic [ChanW-1:0] clip_chan(input int c, input int t, input int b,
                                                 input int l, input int r);
    int v;
    v = 5 * c - t - b - l - r;
    if (v < 0) v = 0;
    else if (v > 255) v = 255;
    return v[ChanW-1:0];
  endfunction

  function automatic pixel_t sharpen_px(input pixel_t c, input pixel_t t, input pixel_t b,
                                        input pixel_t l, input pixel_t r);
    pixel_t o;
    o.red   = clip_chan(c.red, t.red, b.red, l.red, r.red);
    o.green = clip_chan(c.green, t.green, b.green, l.green, r.green);
    o.blue  = clip_chan(c.blue, t.blue, b.blue, l.blue, r.blue);
    return o;
  endfunction

  function automatic sharp_res_t make_res(input int unsigned col, input int unsigned row,
                                          input pixel_t pix, input logic fend);
    sharp_res_t o;
    o.col       = col[ColW-1:0];
    o.row       = row[RowW-1:0];
    o.pix       = pix;
    o.run_last  = 1'b0;
    o.frame_end = fend;
    return o;
  endfunction

  function automatic string res_str(input sharp_res_t r);
    return $sformatf("col %0d row %0d rgb %02h %02h %02h last %0b fend %0b", r.col, r.row,
                     r.pix.red, r.pix.green, r.pix.blue, r.run_last, r.frame_end);
  endfunction

  task automatic note_failure(input string what);
    if (mismatch_count < MaxReports) $display("%0t: %s", $time, what);
    mismatch_count++;
  endtask

  // works out the results one accepted pixel causes and advances the window state
  task automatic predict_sharpened(input pixel_t px);
    int unsigned w, h, x, y, n, i;
    logic        row_end, last_row;
    pixel_t      up, up_right, up2, ctr;
    sharp_res_t  res [3];
    w = (width_q == 0) ? 1 : width_q;
    if (w > MaxWidth) w = MaxWidth;
    h = (height_q == 0) ? 1 : height_q;
    x = (col_q >= MaxWidth) ? MaxWidth - 1 : col_q;
    y = row_q;
    row_end  = (x + 1 >= w);
    last_row = (y + 1 >= h);
    up       = above_mem[x];
    up_right = row_end ? up : above_mem[x + 1];
    up2      = two_above_mem[x];
    n = 0;
    // pixel one row up is now complete
    if (y >= 1) begin
      res[n] = make_res(x, y - 1, sharpen_px(up, (y == 1) ? up : up2, px,
                                             (x == 0) ? up : recent_q[2], up_right), 1'b0);
      n++;
    end
    if (last_row) begin
      // left neighbour on the last row, with the bottom replicated
      if (x >= 1) begin
        ctr    = recent_q[0];
        res[n] = make_res(x - 1, y, sharpen_px(ctr, (y == 0) ? ctr : recent_q[2], ctr,
                                               (x == 1) ? ctr : recent_q[1], px), 1'b0);
        n++;
      end
      // final pixel of the row closes itself
      if (row_end) begin
        res[n] = make_res(x, y, sharpen_px(px, (y == 0) ? px : up, px,
                                           (x == 0) ? px : recent_q[0], px), 1'b1);
        n++;
      end
    end
    two_above_mem[x] = up;
    above_mem[x]     = px;
    recent_q[3]      = recent_q[2];
    recent_q[2]      = up;
    recent_q[1]      = recent_q[0];
    recent_q[0]      = px;
    if (row_end) begin
      col_q = 0;
      row_q = last_row ? 0 : ((y + 1) & 32'hFFFF);
    end else begin
      col_q = x + 1;
    end
    if (n > 0) res[n - 1].run_last = 1'b1;
    for (i = 0; i < n; i++) sharpened_q.push_back(res[i]);
  endtask

  task automatic check_word(input logic [OutTdataW-1:0] d, input logic tl, input logic tu);
    sharp_res_t got, exp_res;
    got.col       = d[ColW-1:0];
    got.row       = d[ColW +: RowW];
    got.pix.red   = d[ColW + RowW +: ChanW];
    got.pix.green = d[ColW + RowW + ChanW +: ChanW];
    got.pix.blue  = d[ColW + RowW + 2 * ChanW +: ChanW];
    got.run_last  = tl;
    got.frame_end = tu;
    if (sharpened_q.size() == 0) begin
      note_failure({"unexpected result word: ", res_str(got)});
    end else begin
      exp_res = sharpened_q.pop_front();
      if (got.col !== exp_res.col || got.row !== exp_res.row ||
          got.pix.red !== exp_res.pix.red || got.pix.green !== exp_res.pix.green ||
          got.pix.blue !== exp_res.pix.blue || got.run_last !== exp_res.run_last ||
          got.frame_end !== exp_res.frame_end) begin
        note_failure({"result mismatch: expected ", res_str(exp_res), " got ", res_str(got)});
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  = WidthReset;
      height_q = HeightReset;
      col_q    = 0;
      row_q    = 0;
      foreach (recent_q[k]) recent_q[k] = '0;
      sharpened_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_reg_e'(cfg_addr_i))
          CFG_IMAGE_WIDTH:  width_q  = cfg_data_i[WidthRegW-1:0];
          CFG_IMAGE_HEIGHT: height_q = cfg_data_i[HeightRegW-1:0];
          default: ;
        endcase
      end
      // results on the same edge stem from earlier pixels
      if (m_tvalid_i && m_tready_i) check_word(m_tdata_i, m_tlast_i, m_tuser_i);
      if (s_tvalid_i && s_tready_i) predict_sharpened(pixel_t'(s_tdata_i));
    end
    pending_o    = sharpened_q.size();
    fail_count_o = mismatch_count;
  end

endmodule

// ===== tb/sharpen_3x3_convolution_top_tb.sv =====
// testbench top for the sharpen filter: stimulus, back-pressure, watchdog and verdict
module sharpen_3x3_convolution_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import shc_pkg::*;

  localparam realtime HalfPeriod  = 4.0;
  localparam int      ResetCycles = 8;
  localparam int      SettlePause = 6;     // covers the compute stage and output group with margin
  localparam int      EndSettle   = 20;
  localparam int      HoldCycles  = 200;   // long receiver hold-off
  localparam int      StallLimit  = 2000;  // cycles without any accepted word
  localparam int      PhaseItems  = 55;

  logic                 clk_i;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata;
  logic                 m_axis_tlast;
  logic                 m_axis_tuser;
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgAddrW-1:0]  cfg_addr_i    = '0;
  logic [CfgDataW-1:0]  cfg_data_i    = '0;

  int                   fail_count;
  int                   pending_words;

  // idling knobs, in percent of cycles
  int                   idle_pct  = 0;
  int                   stall_pct = 0;
  logic                 hold_on   = 1'b0;
  event                 hold_start;

  // raw register contents as last written, to size each frame
  logic [WidthRegW-1:0]  width_reg  = WidthReset;
  logic [HeightRegW-1:0] height_reg = HeightReset;

  sharpen_3x3_convolution_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i)
  );

  sharpen_3x3_convolution_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .m_tlast_i    (m_axis_tlast),
    .m_tuser_i    (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending_words)
  );

  // 8 ns clock
  initial begin
    clk_i = 1'b0;
    forever #(HalfPeriod) clk_i = ~clk_i;
  end

  // receiver: random stalls, forced low during a hold-off
  initial begin
    forever begin
      @(negedge clk_i);
      m_axis_tready <= !hold_on && ($urandom_range(99) >= stall_pct);
    end
  end

  // long hold-off, counted here so the sender keeps offering words meanwhile
  initial begin
    forever begin
      @(hold_start);
      @(posedge clk_i);
      hold_on = 1'b1;
      repeat (HoldCycles) @(posedge clk_i);
      hold_on = 1'b0;
    end
  end

  // watchdog: any accepted word on any channel restarts the count
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < StallLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("*** FAILED ***");
    $finish;
  end

  // effective sizes, with the out-of-range values folded as the block does
  function automatic int unsigned eff_width();
    int unsigned w;
    w = (width_reg == 0) ? 1 : width_reg;
    return (w > MaxWidth) ? MaxWidth : w;
  endfunction

  function automatic int unsigned eff_height();
    return (height_reg == 0) ? 1 : height_reg;
  endfunction

  // mostly random channels, a quarter of pixels at the channel extremes
  function automatic pixel_t rand_px();
    pixel_t px;
    px = pixel_t'(InTdataW'($urandom));
    if ($urandom_range(3) == 0) begin
      px.red   = $urandom_range(1) ? ChanMax : '0;
      px.green = $urandom_range(1) ? ChanMax : '0;
      px.blue  = $urandom_range(1) ? ChanMax : '0;
    end
    return px;
  endfunction

  // register write; called at a falling edge, returns at a falling edge
  task automatic write_reg(input cfg_reg_e idx, input logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
    if (idx == CFG_IMAGE_WIDTH) width_reg = data[WidthRegW-1:0];
    else height_reg = data;
  endtask

  // one pixel word; valid stays high into the next word unless the sender idles
  task automatic send_pixel(input pixel_t px);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // sender pauses until every predicted word has come, then lets the pipe settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_words != 0) @(negedge clk_i);
    repeat (SettlePause) @(negedge clk_i);
  endtask

  task automatic send_random(input int unsigned count);
    int unsigned i;
    for (i = 0; i < count; i++) send_pixel(rand_px());
    drain();
  endtask

  // whole frames of random size until the phase has seen enough pixels
  task automatic random_phase(input int s_pct, input int r_pct);
    int unsigned sent, pick, w;
    logic [CfgDataW-1:0] wdata;
    idle_pct  = s_pct;
    stall_pct = r_pct;
    sent = 0;
    while (sent < PhaseItems) begin
      pick = $urandom_range(2);
      if (pick != 1) begin
        w     = $urandom_range(9);
        wdata = CfgDataW'(w);
        // bits above the width register are dropped by the block
        if ($urandom_range(2) == 0) begin
          wdata[CfgDataW-1:WidthRegW] = (CfgDataW - WidthRegW)'($urandom);
        end
        write_reg(CFG_IMAGE_WIDTH, wdata);
      end
      if (pick != 0) write_reg(CFG_IMAGE_HEIGHT, CfgDataW'($urandom_range(5)));
      send_random(eff_width() * eff_height());
      sent += eff_width() * eff_height();
    end
  endtask

  initial begin
    int unsigned i;
    pixel_t      px;

    repeat (ResetCycles) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // ---- directed part, no idling ----
    // 3x3 checkerboard of black and white drives both saturation limits
    write_reg(CFG_IMAGE_WIDTH, CfgDataW'(3));
    write_reg(CFG_IMAGE_HEIGHT, CfgDataW'(3));
    for (i = 0; i < 9; i++) begin
      px = (i % 2) ? pixel_t'('1) : pixel_t'('0);
      if (i == 4) px = pixel_t'(24'h80_00_FF);   // channels apart in the centre
      send_pixel(px);
    end
    drain();

    // zero width and zero height fold to a single pixel image
    write_reg(CFG_IMAGE_WIDTH, '0);
    write_reg(CFG_IMAGE_HEIGHT, '0);
    send_pixel(pixel_t'('1));
    drain();

    // tallest image, cut short mid-frame by a smaller height
    write_reg(CFG_IMAGE_WIDTH, CfgDataW'(1));
    write_reg(CFG_IMAGE_HEIGHT, '1);
    for (i = 0; i < 3; i++) send_pixel(rand_px());
    drain();
    write_reg(CFG_IMAGE_HEIGHT, CfgDataW'(2));
    send_pixel(rand_px());
    drain();

    // single-row image
    write_reg(CFG_IMAGE_WIDTH, CfgDataW'(2));
    write_reg(CFG_IMAGE_HEIGHT, CfgDataW'(1));
    send_random(2);

    // width narrowed at a row boundary inside a frame
    write_reg(CFG_IMAGE_WIDTH, CfgDataW'(4));
    write_reg(CFG_IMAGE_HEIGHT, CfgDataW'(3));
    for (i = 0; i < 4; i++) send_pixel(rand_px());
    drain();
    write_reg(CFG_IMAGE_WIDTH, CfgDataW'(2));
    send_random(4);

    // oversized width register on a single row, closed early by a width of one
    write_reg(CFG_IMAGE_WIDTH, CfgDataW'(12'hFFF));
    write_reg(CFG_IMAGE_HEIGHT, CfgDataW'(1));
    send_random(6);
    write_reg(CFG_IMAGE_WIDTH, CfgDataW'(1));
    send_random(1);

    // ---- random part ----
    random_phase(0, 0);    // free-running
    random_phase(75, 0);   // sparse input
    random_phase(0, 75);   // heavy back-pressure
    random_phase(29, 29);  // both sides idle now and then

    // receiver holds off while the sender keeps pushing, filling the block
    idle_pct  = 0;
    stall_pct = 0;
    write_reg(CFG_IMAGE_WIDTH, CfgDataW'(8));
    write_reg(CFG_IMAGE_HEIGHT, CfgDataW'(6));
    -> hold_start;
    send_random(eff_width() * eff_height());

    // nothing left to come; a stray word in the settle window is still caught
    drain();
    repeat (EndSettle) @(negedge clk_i);
    if (fail_count == 0 && pending_words == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
